@@ rtl/core/mra_pkg.sv @@
// Shared types and constants for the perceptron inference core.
`default_nettype none
package mra_pkg;

  localparam int FEATURES    = 6;
  localparam int ACTIONS     = 2;
  localparam int DATA_W      = 16;
  localparam int CFG_W       = 5;
  localparam int FIDX_W      = 3;
  localparam int FRAC        = 12;
  localparam int HIDDEN_RST  = 6;
  localparam int WIDX_W      = 8;

  // Q4.12 one, used to align a bias to the product scale
  localparam logic signed [DATA_W-1:0] ONE_Q12 = 16'sd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_L1,
    ST_DRAIN1,
    ST_PAD,
    ST_L2,
    ST_DRAIN2
  } mra_state_t;

  // control that travels with one multiply-accumulate op
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              sel;
    logic              bias;
    logic              l2;
    logic              push;
    logic              shift;
    logic              fin;
    logic [FIDX_W-1:0] fidx;
  } mra_op_t;

endpackage
`default_nettype wire

@@ rtl/core/mra_cell.sv @@
// One hidden-value cell of the shift chain.
`default_nettype none
module mra_cell (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [mra_pkg::DATA_W-1:0] d,
  output logic signed [mra_pkg::DATA_W-1:0]      q
);

  logic signed [mra_pkg::DATA_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

@@ rtl/core/mra_mac.sv @@
// Shared multiplier and the two accumulators, with ReLU and saturation of hidden sums.
`default_nettype none
module mra_mac #(
  parameter int ACC_W = 37
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mra_pkg::mra_op_t                  op_b,
  input  wire logic signed [mra_pkg::DATA_W-1:0] opnd_a,
  input  wire logic signed [mra_pkg::DATA_W-1:0] opnd_b,
  output logic signed [ACC_W-1:0]                acc0,
  output logic signed [ACC_W-1:0]                acc1,
  output logic                                   push_vld,
  output logic signed [mra_pkg::DATA_W-1:0]      push_val,
  output logic                                   fin
);

  localparam int PROD_W = 2 * mra_pkg::DATA_W;
  localparam int TOP    = mra_pkg::FRAC + mra_pkg::DATA_W - 1;

  logic signed [PROD_W-1:0] prod_r;
  mra_pkg::mra_op_t         op_c_r;
  logic signed [ACC_W-1:0]  acc0_r;
  logic signed [ACC_W-1:0]  acc1_r;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_c_r <= '0;
    end else begin
      op_c_r <= op_b;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= opnd_a * opnd_b;
  end

  always_comb begin
    if (op_c_r.first) begin
      base = '0;
    end else if (op_c_r.sel) begin
      base = acc1_r;
    end else begin
      base = acc0_r;
    end
    sum = base + ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (op_c_r.valid) begin
      if (op_c_r.sel) begin
        acc1_r <= sum;
      end else begin
        acc0_r <= sum;
      end
    end
  end

  always_comb begin
    if (sum[ACC_W-1]) begin
      push_val = '0;
    end else if (|sum[ACC_W-1:TOP]) begin
      push_val = 16'sh7fff;
    end else begin
      push_val = {1'b0, sum[TOP-1:mra_pkg::FRAC]};
    end
  end

  assign push_vld = op_c_r.valid & op_c_r.push;
  assign fin      = op_c_r.valid & op_c_r.fin;
  assign acc0     = acc0_r;
  assign acc1     = acc1_r;

endmodule
`default_nettype wire

@@ rtl/core/mlp_relu_argmax_inference_core.sv @@
// Top level of the two-layer perceptron inference core.
//
// Usage: an item is taken when start is high and busy is low. A load item
// (in_kind 0) writes in_weight_value to the weight store at in_weight_index
// in that cycle and leaves busy low; indexes past the store are dropped.
// An infer item (in_kind 1) captures the six features and raises busy.
// Weights must be loaded before an inference reads them.
// One shared multiplier runs one product a cycle through a 3-stage pipe
// (store read, multiply, accumulate). Hidden values enter a chain of
// MAX_HIDDEN cells that shifts one place per step and feeds layer 2.
// Items are handled one at a time.
// The result shows on out_action/out_best_score for one cycle with
// out_valid; the receiver cannot stall it. Load items give no result.
// cfg_we writes hidden_used from cfg_wdata; write it only while idle.
// Reset (rst_n low, synchronous) sets hidden_used to 6 and returns to idle;
// the weight store keeps its contents and is undefined until written.
`default_nettype none
module mlp_relu_argmax_inference_core #(
  parameter int MAX_HIDDEN = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_kind,
  input  wire logic [mra_pkg::WIDX_W-1:0]        in_weight_index,
  input  wire logic signed [mra_pkg::DATA_W-1:0] in_weight_value,
  input  wire logic signed [mra_pkg::DATA_W-1:0] in_feature_0,
  input  wire logic signed [mra_pkg::DATA_W-1:0] in_feature_1,
  input  wire logic signed [mra_pkg::DATA_W-1:0] in_feature_2,
  input  wire logic signed [mra_pkg::DATA_W-1:0] in_feature_3,
  input  wire logic signed [mra_pkg::DATA_W-1:0] in_feature_4,
  input  wire logic signed [mra_pkg::DATA_W-1:0] in_feature_5,
  output logic                                   out_valid,
  output logic                                   out_action,
  output logic signed [mra_pkg::DATA_W-1:0]      out_best_score,
  input  wire logic                              cfg_we,
  input  wire logic [mra_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int DEPTH  = (mra_pkg::FEATURES + 1) * MAX_HIDDEN
                          + mra_pkg::ACTIONS * (MAX_HIDDEN + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int HW     = $clog2(MAX_HIDDEN + 1);
  localparam int ACC_W  = 32 + $clog2(MAX_HIDDEN + 2);
  localparam int TOP    = mra_pkg::FRAC + mra_pkg::DATA_W - 1;
  localparam int DW     = mra_pkg::DATA_W;

  logic [mra_pkg::CFG_W-1:0] hidden_used_r;
  mra_pkg::mra_state_t       st_r, st_nxt;
  logic [HW-1:0]             h_r, h_nxt;
  logic [HW-1:0]             h_calc;
  logic [HW-1:0]             pad_r, pad_nxt;
  logic [HW-1:0]             j_r, j_nxt;
  logic [HW-1:0]             k_r, k_nxt;
  logic [mra_pkg::FIDX_W-1:0] i_r, i_nxt;
  logic                      s_r, s_nxt;
  logic [ADDR_W-1:0]         p0_r, p0_nxt;
  logic [ADDR_W-1:0]         p1_r, p1_nxt;
  logic [ADDR_W-1:0]         rd_addr;
  mra_pkg::mra_op_t          op_a;
  mra_pkg::mra_op_t          op_b_r;
  logic                      pad_shift;
  logic                      accept;
  logic                      done_r;
  logic                      out_valid_r;
  logic                      out_action_r;
  logic signed [DW-1:0]      out_best_r;

  logic signed [DW-1:0]      feat_r [mra_pkg::FEATURES];
  logic signed [DW-1:0]      mem [DEPTH];
  logic signed [DW-1:0]      mem_rd_r;
  logic signed [DW-1:0]      opnd_b;

  logic signed [DW-1:0]      chain_q [MAX_HIDDEN];
  logic                      chain_en;
  logic signed [DW-1:0]      chain_in;

  logic signed [ACC_W-1:0]   acc0, acc1;
  logic                      push_vld;
  logic signed [DW-1:0]      push_val;
  logic                      fin;

  logic                      pick1;
  logic signed [ACC_W-1:0]   best_acc;
  logic signed [DW-1:0]      best_sat;

  assign accept = start & ~busy;
  assign busy   = (st_r != mra_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidden_used_r <= mra_pkg::CFG_W'(mra_pkg::HIDDEN_RST);
    end else if (cfg_we) begin
      hidden_used_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (hidden_used_r == '0) begin
      h_calc = HW'(1);
    end else if (32'(hidden_used_r) > MAX_HIDDEN) begin
      h_calc = HW'(MAX_HIDDEN);
    end else begin
      h_calc = HW'(hidden_used_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind) begin
      feat_r[0] <= in_feature_0;
      feat_r[1] <= in_feature_1;
      feat_r[2] <= in_feature_2;
      feat_r[3] <= in_feature_3;
      feat_r[4] <= in_feature_4;
      feat_r[5] <= in_feature_5;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_kind && (32'(in_weight_index) < DEPTH)) begin
      mem[ADDR_W'(in_weight_index)] <= in_weight_value;
    end
    mem_rd_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mra_pkg::ST_IDLE: begin
        if (accept && in_kind) begin
          st_nxt = mra_pkg::ST_L1;
        end
      end
      mra_pkg::ST_L1: begin
        if ((32'(i_r) == mra_pkg::FEATURES) && (j_r == h_r - HW'(1))) begin
          st_nxt = mra_pkg::ST_DRAIN1;
        end
      end
      mra_pkg::ST_DRAIN1: begin
        if (!op_b_r.valid && !push_vld) begin
          st_nxt = (pad_r == '0) ? mra_pkg::ST_L2 : mra_pkg::ST_PAD;
        end
      end
      mra_pkg::ST_PAD: begin
        if (pad_r == HW'(1)) begin
          st_nxt = mra_pkg::ST_L2;
        end
      end
      mra_pkg::ST_L2: begin
        if (s_r && (k_r == h_r)) begin
          st_nxt = mra_pkg::ST_DRAIN2;
        end
      end
      mra_pkg::ST_DRAIN2: begin
        if (done_r) begin
          st_nxt = mra_pkg::ST_IDLE;
        end
      end
      default: st_nxt = mra_pkg::ST_IDLE;
    endcase
  end

  // op issue and counters
  always_comb begin
    op_a      = '0;
    rd_addr   = p0_r;
    pad_shift = 1'b0;
    h_nxt     = h_r;
    pad_nxt   = pad_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    case (st_r)
      mra_pkg::ST_IDLE: begin
        h_nxt   = h_calc;
        pad_nxt = HW'(MAX_HIDDEN) - h_calc;
        j_nxt   = '0;
        k_nxt   = '0;
        i_nxt   = '0;
        s_nxt   = 1'b0;
        p0_nxt  = '0;
      end
      mra_pkg::ST_L1: begin
        op_a.valid = 1'b1;
        op_a.first = (i_r == '0);
        op_a.bias  = (32'(i_r) == mra_pkg::FEATURES);
        op_a.push  = (32'(i_r) == mra_pkg::FEATURES);
        op_a.fidx  = i_r;
        p0_nxt     = p0_r + ADDR_W'(1);
        if (32'(i_r) == mra_pkg::FEATURES) begin
          i_nxt = '0;
          j_nxt = j_r + HW'(1);
        end else begin
          i_nxt = i_r + mra_pkg::FIDX_W'(1);
        end
      end
      mra_pkg::ST_DRAIN1: begin
        p1_nxt = p0_r + ADDR_W'(h_r) + ADDR_W'(1);
      end
      mra_pkg::ST_PAD: begin
        pad_shift = 1'b1;
        pad_nxt   = pad_r - HW'(1);
      end
      mra_pkg::ST_L2: begin
        rd_addr    = s_r ? p1_r : p0_r;
        op_a.valid = 1'b1;
        op_a.l2    = 1'b1;
        op_a.sel   = s_r;
        op_a.first = (k_r == '0);
        op_a.bias  = (k_r == h_r);
        op_a.shift = s_r && (k_r != h_r);
        op_a.fin   = s_r && (k_r == h_r);
        s_nxt      = ~s_r;
        if (s_r) begin
          p0_nxt = p0_r + ADDR_W'(1);
          p1_nxt = p1_r + ADDR_W'(1);
          k_nxt  = k_r + HW'(1);
        end
      end
      mra_pkg::ST_DRAIN2: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= mra_pkg::ST_IDLE;
      op_b_r <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      op_b_r <= op_a;
      done_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    pad_r <= pad_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    s_r   <= s_nxt;
    p0_r  <= p0_nxt;
    p1_r  <= p1_nxt;
  end

  always_comb begin
    if (op_b_r.bias) begin
      opnd_b = mra_pkg::ONE_Q12;
    end else if (op_b_r.l2) begin
      opnd_b = chain_q[0];
    end else begin
      case (op_b_r.fidx)
        3'd0:    opnd_b = feat_r[0];
        3'd1:    opnd_b = feat_r[1];
        3'd2:    opnd_b = feat_r[2];
        3'd3:    opnd_b = feat_r[3];
        3'd4:    opnd_b = feat_r[4];
        3'd5:    opnd_b = feat_r[5];
        default: opnd_b = '0;
      endcase
    end
  end

  mra_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_b     (op_b_r),
    .opnd_a   (mem_rd_r),
    .opnd_b   (opnd_b),
    .acc0     (acc0),
    .acc1     (acc1),
    .push_vld (push_vld),
    .push_val (push_val),
    .fin      (fin)
  );

  assign chain_en = pad_shift | (op_b_r.valid & op_b_r.shift) | push_vld;
  assign chain_in = push_vld ? push_val : '0;

  for (genvar g = 0; g < MAX_HIDDEN; g++) begin : g_chain
    if (g == MAX_HIDDEN - 1) begin : g_tail
      mra_cell u_cell (
        .clk (clk),
        .en  (chain_en),
        .d   (chain_in),
        .q   (chain_q[g])
      );
    end else begin : g_mid
      mra_cell u_cell (
        .clk (clk),
        .en  (chain_en),
        .d   (chain_q[g+1]),
        .q   (chain_q[g])
      );
    end
  end

  assign pick1    = (acc1 > acc0);
  assign best_acc = pick1 ? acc1 : acc0;

  always_comb begin
    if ((&best_acc[ACC_W-1:TOP]) || !(|best_acc[ACC_W-1:TOP])) begin
      best_sat = best_acc[TOP:mra_pkg::FRAC];
    end else if (best_acc[ACC_W-1]) begin
      best_sat = 16'sh8000;
    end else begin
      best_sat = 16'sh7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (done_r) begin
      out_action_r <= pick1;
      out_best_r   <= best_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_best_score = out_best_r;

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in flight");

  a_pad_no_l2_shift: assert property (@(posedge clk) disable iff (!rst_n)
    pad_shift |-> !(op_b_r.valid && op_b_r.shift) && !push_vld)
    else $error("chain shifted from two sources");

  a_push_in_l1: assert property (@(posedge clk) disable iff (!rst_n)
    push_vld |-> (st_r == mra_pkg::ST_L1 || st_r == mra_pkg::ST_DRAIN1))
    else $error("hidden push outside layer 1");

  a_infer_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind) |=> (st_r == mra_pkg::ST_L1))
    else $error("infer item did not start layer 1");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mra_pkg::ST_IDLE) |-> !op_b_r.valid && !fin)
    else $error("pipeline busy while idle");

endmodule
`default_nettype wire
